// ===== rtl/opke_pkg.sv =====
// ----------------------------------------------------------------------------
// opke_pkg
// Shared types and constants of the order-preserving key encoder.
// ----------------------------------------------------------------------------
package opke_pkg;

  localparam int unsigned OpW       = 4;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxBytes  = 12;
  localparam int unsigned LenW      = 4;
  localparam int unsigned NumTags   = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;

  localparam logic [ByteW-1:0] ByteZero   = 8'h00;
  localparam logic [ByteW-1:0] ByteOne    = 8'h01;
  localparam logic [ByteW-1:0] ByteEscape = 8'hFF;
  localparam logic [ByteW-1:0] SignPos    = 8'h03;
  localparam logic [ByteW-1:0] SignNeg    = 8'h02;

  typedef enum logic [OpW-1:0] {
    OP_STR_START = 4'd0,
    OP_STR_BYTE  = 4'd1,
    OP_STR_END   = 4'd2,
    OP_INT16     = 4'd3,
    OP_INT32     = 4'd4,
    OP_INT64     = 4'd5,
    OP_BOOL      = 4'd6,
    OP_NULL_FST  = 4'd7,
    OP_NULL_LST  = 4'd8
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TAG_STRING = 3'd0,
    REG_TAG_INT16  = 3'd1,
    REG_TAG_INT32  = 3'd2,
    REG_TAG_INT64  = 3'd3,
    REG_TAG_BOOL   = 3'd4,
    REG_TAG_NULL_F = 3'd5,
    REG_TAG_NULL_L = 3'd6
  } reg_e;

  localparam logic [NumTags-1:0][ByteW-1:0] TagReset = {
    8'd11, 8'd0, 8'd7, 8'd4, 8'd3, 8'd2, 8'd1
  };

  typedef struct packed {
    logic [LenW-1:0]                 len;
    logic [MaxBytes-1:0][ByteW-1:0]  bytes;
  } cmd_t;

endpackage

// ===== rtl/opke_front.sv =====
// ----------------------------------------------------------------------------
// opke_front
// Holds the tag registers, accepts requests and expands each into a burst.
// ----------------------------------------------------------------------------
module opke_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [opke_pkg::OpW-1:0]    operation_i,
  input  logic [opke_pkg::ValueW-1:0] value_i,
  input  logic                        cfg_valid_i,
  input  logic [opke_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [opke_pkg::ByteW-1:0]  cfg_data_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output opke_pkg::cmd_t              cmd_o
);
  import opke_pkg::*;

  logic [NumTags-1:0][ByteW-1:0] tag_q;
  logic [ValueW-1:0]             dec;
  logic [ValueW-1:0]             mag;
  logic                          neg;
  logic                          cmd_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TagReset;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_TAG_STRING: tag_q[0] <= cfg_data_i;
        REG_TAG_INT16:  tag_q[1] <= cfg_data_i;
        REG_TAG_INT32:  tag_q[2] <= cfg_data_i;
        REG_TAG_INT64:  tag_q[3] <= cfg_data_i;
        REG_TAG_BOOL:   tag_q[4] <= cfg_data_i;
        REG_TAG_NULL_F: tag_q[5] <= cfg_data_i;
        REG_TAG_NULL_L: tag_q[6] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The inverted magnitude of a negative value equals the value minus one.
  assign dec = value_i - ValueW'(1);

  always_comb begin
    cmd_o  = '0;
    cmd_ok = 1'b1;
    neg    = 1'b0;
    mag    = value_i;
    case (op_e'(operation_i))
      OP_STR_START: begin
        cmd_o.len      = LenW'(1);
        cmd_o.bytes[0] = tag_q[0];
      end
      OP_STR_BYTE: begin
        cmd_o.bytes[0] = value_i[ByteW-1:0];
        cmd_o.bytes[1] = ByteEscape;
        cmd_o.len      = (value_i[ByteW-1:0] == ByteZero) ? LenW'(2) : LenW'(1);
      end
      OP_STR_END: begin
        cmd_o.len      = LenW'(2);
        cmd_o.bytes[0] = ByteZero;
        cmd_o.bytes[1] = ByteOne;
      end
      OP_INT16: begin
        neg            = value_i[15];
        mag            = neg ? dec : value_i;
        cmd_o.len      = LenW'(6);
        cmd_o.bytes[0] = tag_q[1];
        cmd_o.bytes[1] = neg ? SignNeg : SignPos;
        for (int i = 0; i < 2; i++) begin
          cmd_o.bytes[2+i] = mag[8*(1-i) +: 8];
        end
        cmd_o.bytes[4] = ByteZero;
        cmd_o.bytes[5] = ByteOne;
      end
      OP_INT32: begin
        neg            = value_i[31];
        mag            = neg ? dec : value_i;
        cmd_o.len      = LenW'(8);
        cmd_o.bytes[0] = tag_q[2];
        cmd_o.bytes[1] = neg ? SignNeg : SignPos;
        for (int i = 0; i < 4; i++) begin
          cmd_o.bytes[2+i] = mag[8*(3-i) +: 8];
        end
        cmd_o.bytes[6] = ByteZero;
        cmd_o.bytes[7] = ByteOne;
      end
      OP_INT64: begin
        neg            = value_i[63];
        mag            = neg ? dec : value_i;
        cmd_o.len      = LenW'(12);
        cmd_o.bytes[0] = tag_q[3];
        cmd_o.bytes[1] = neg ? SignNeg : SignPos;
        for (int i = 0; i < 8; i++) begin
          cmd_o.bytes[2+i] = mag[8*(7-i) +: 8];
        end
        cmd_o.bytes[10] = ByteZero;
        cmd_o.bytes[11] = ByteOne;
      end
      OP_BOOL: begin
        cmd_o.len      = LenW'(4);
        cmd_o.bytes[0] = tag_q[4];
        cmd_o.bytes[1] = (value_i != '0) ? ByteOne : ByteZero;
        cmd_o.bytes[2] = ByteZero;
        cmd_o.bytes[3] = ByteOne;
      end
      OP_NULL_FST: begin
        cmd_o.len      = LenW'(3);
        cmd_o.bytes[0] = tag_q[5];
        cmd_o.bytes[1] = ByteZero;
        cmd_o.bytes[2] = ByteOne;
      end
      OP_NULL_LST: begin
        cmd_o.len      = LenW'(3);
        cmd_o.bytes[0] = tag_q[6];
        cmd_o.bytes[1] = ByteZero;
        cmd_o.bytes[2] = ByteOne;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && cmd_ok;

endmodule

// ===== rtl/opke_fifo.sv =====
// ----------------------------------------------------------------------------
// opke_fifo
// Short queue of expanded bursts between the front and the serializer.
// ----------------------------------------------------------------------------
module opke_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  opke_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output opke_pkg::cmd_t head_cmd_o
);
  import opke_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

endmodule

// ===== rtl/opke_back.sv =====
// ----------------------------------------------------------------------------
// opke_back
// Serializes the queued bursts into key bytes through an output register.
// ----------------------------------------------------------------------------
module opke_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  opke_pkg::cmd_t             head_cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [opke_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_last_o
);
  import opke_pkg::*;

  logic [LenW-1:0]  idx_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;
  logic             load;
  logic             is_last;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == (head_cmd_i.len - LenW'(1)));
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? '0 : idx_q + LenW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= head_cmd_i.bytes[idx_q];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_cmd_i.len))
    else $error("byte index beyond burst length");

  a_no_empty_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (head_cmd_i.len != '0))
    else $error("empty burst queued");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0))
    else $error("byte index did not restart after the final byte");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (out_last_q == $past(is_last))))
    else $error("final byte flag lost");

endmodule

// ===== rtl/order_preserving_key_encoder.sv =====
// ----------------------------------------------------------------------------
// order_preserving_key_encoder
// Turns typed key fields into bytes that sort like the values they encode.
// ----------------------------------------------------------------------------
// Each request expands into a burst of 1 to 12 key bytes that leaves on the
// master side one byte per cycle while m_axis_tready is high, with tlast on
// the burst's final byte. A burst holds one byte for a string start or a
// nonzero string byte, two for a zero string byte or a string end, three for
// a null, four for a bool, and 6, 8 or 12 for a 16-, 32- or 64-bit integer.
// The front takes a new request every cycle while the two-entry burst queue
// has room, so plain string bytes stream at full rate. Tag registers are
// written through the configuration channel, which is always ready.
module order_preserving_key_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [3:0] operation, [67:4] value, [71:68] zero
  input  logic [opke_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] key_byte
  output logic [opke_pkg::ByteW-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [opke_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [opke_pkg::ByteW-1:0]    cfg_data_i
);
  import opke_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;

  opke_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .operation_i (s_axis_tdata_i[OpW-1:0]),
    .value_i     (s_axis_tdata_i[OpW +: ValueW]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  opke_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  opke_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
